// ===== sv/pbqe_pkg.sv =====
// shared constants and codes for the particle billboard quad expander
// no dependencies
`default_nettype none

package pbqe_pkg;

	// default number of angle steps in one full turn
	localparam int unsigned ANGLE_STEPS_DEF = 256;

	// 2^32 / (2*pi), 2^30 * pi/2, 1.0 in q30
	localparam longint unsigned INV_TWO_PI_Q32 = 64'd683565276;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	localparam int unsigned POS_W = 24;
	localparam int unsigned VEC_W = 16;
	localparam int unsigned ADDR_W = 6;
	localparam int unsigned DATA_W = 64;

	// config register indexes, 8-byte stride
	typedef enum logic [2:0] {
		REG_CAMERA_UP = 3'd0,
		REG_CAMERA_RIGHT = 3'd1,
		REG_FACING_NORMAL = 3'd2,
		REG_COLOR_SCALE = 3'd3,
		REG_ROTATION_ENABLE = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CORNER_UL = 2'd0,
		CORNER_UR = 2'd1,
		CORNER_BR = 2'd2,
		CORNER_BL = 2'd3
	} corner_t;

endpackage

`default_nettype wire

// ===== sv/particle_billboard_quad_expand.sv =====
// particle billboard quad expander: one particle in, four quad vertices out
// depends on pbqe_pkg (constants, register and corner codes)
`default_nettype none

// Each particle transfer produces four vertex transfers, upper left, upper right,
// bottom right, bottom left, with last_corner set on the fourth. Particles flow
// through a five-stage pipeline (angle multiply and colour products, angle step
// and colour rounding, cosine/sine table read, up vector rotation, cross product
// with the normal) into a hold register that issues one corner per cycle, while
// the vertex path does not stall, into a two-stage vertex path (offset times
// size, then add and saturate). The hold register takes a new particle only
// once its fourth corner issues to the single vertex output. The cosine and
// sine table has ANGLE_STEPS entries and is built at elaboration. Registers sit
// at byte address 8*index on the 64-bit port and should be written only while
// the block is idle; rotation_enable selects rotated or plain camera vectors.
module particle_billboard_quad_expand #(
	parameter int unsigned ANGLE_STEPS = pbqe_pkg::ANGLE_STEPS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// config port
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [pbqe_pkg::ADDR_W-1:0] paddr,
	input  wire logic [pbqe_pkg::DATA_W-1:0] pwdata,
	output logic [pbqe_pkg::DATA_W-1:0] prdata,
	output logic pready,
	// particle channel
	input  wire logic item_valid,
	output logic item_stall,
	input  wire logic signed [23:0] pos_x,
	input  wire logic signed [23:0] pos_y,
	input  wire logic signed [23:0] pos_z,
	input  wire logic [15:0] half_size,
	input  wire logic signed [15:0] spin_angle,
	input  wire logic [7:0] alpha_in,
	input  wire logic [7:0] red_in,
	input  wire logic [7:0] green_in,
	input  wire logic [7:0] blue_in,
	// vertex channel
	output logic vert_valid,
	input  wire logic vert_stall,
	output logic signed [23:0] vert_x,
	output logic signed [23:0] vert_y,
	output logic signed [23:0] vert_z,
	output logic [31:0] packed_color,
	output logic [1:0] corner,
	output logic last_corner
);

	// angle step scaling: p = angle * ANGLE_STEPS * 2^32/(2 pi), step = round(p / 2^44)
	localparam logic [63:0] KMUL = 64'(ANGLE_STEPS) * pbqe_pkg::INV_TWO_PI_Q32;
	localparam int KW = $clog2(KMUL + 64'd1);
	localparam int PW = 16 + KW + 1;
	localparam int IW = $clog2(ANGLE_STEPS);
	localparam int AW = IW + 4;
	localparam int BUW = 19;     // rotated up vector
	localparam int RTW = 22;     // right vector after cross product
	localparam int OFW = 23;     // corner offset
	localparam int MPW = OFW + 17;

	localparam logic signed [KW:0] KS = (KW+1)'(KMUL);
	localparam logic signed [AW-1:0] STEPS_A = AW'(ANGLE_STEPS);

	typedef logic [31:0] sc_tab_t [ANGLE_STEPS];

	// cos in [31:16], sin in [15:0], both q14, one entry per angle step
	function automatic logic [31:0] sincos_entry(input int unsigned idx);
		logic [63:0] q4, quad, rem, x, x2, t, v, sv, cv;
		logic [15:0] c16, s16;
		q4 = 64'(idx) * 64'd4;
		quad = q4 / ANGLE_STEPS;
		rem = q4 % ANGLE_STEPS;
		x = pbqe_pkg::HALF_PI_Q30 * rem / ANGLE_STEPS;
		x2 = (x * x) >> 30;
		t = pbqe_pkg::ONE_Q30;
		t = pbqe_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
		t = pbqe_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
		t = pbqe_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
		t = pbqe_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
		t = pbqe_pkg::ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
		sv = (((x * t) >> 30) + 64'd32768) >> 16;
		t = pbqe_pkg::ONE_Q30;
		v = ((x2 * t) >> 30) / 64'd132;
		t = (v > pbqe_pkg::ONE_Q30) ? 64'd0 : pbqe_pkg::ONE_Q30 - v;
		v = ((x2 * t) >> 30) / 64'd90;
		t = (v > pbqe_pkg::ONE_Q30) ? 64'd0 : pbqe_pkg::ONE_Q30 - v;
		v = ((x2 * t) >> 30) / 64'd56;
		t = (v > pbqe_pkg::ONE_Q30) ? 64'd0 : pbqe_pkg::ONE_Q30 - v;
		v = ((x2 * t) >> 30) / 64'd30;
		t = (v > pbqe_pkg::ONE_Q30) ? 64'd0 : pbqe_pkg::ONE_Q30 - v;
		v = ((x2 * t) >> 30) / 64'd12;
		t = (v > pbqe_pkg::ONE_Q30) ? 64'd0 : pbqe_pkg::ONE_Q30 - v;
		v = ((x2 * t) >> 30) / 64'd2;
		t = (v > pbqe_pkg::ONE_Q30) ? 64'd0 : pbqe_pkg::ONE_Q30 - v;
		cv = (t + 64'd32768) >> 16;
		case (quad[1:0])
			2'd0: begin
				c16 = cv[15:0];
				s16 = sv[15:0];
			end
			2'd1: begin
				c16 = -sv[15:0];
				s16 = cv[15:0];
			end
			2'd2: begin
				c16 = -cv[15:0];
				s16 = -sv[15:0];
			end
			default: begin
				c16 = sv[15:0];
				s16 = -cv[15:0];
			end
		endcase
		return {c16, s16};
	endfunction

	function automatic sc_tab_t build_tab();
		sc_tab_t tab;
		for (int unsigned i = 0; i < ANGLE_STEPS; i++) begin
			tab[i] = sincos_entry(i);
		end
		return tab;
	endfunction

	localparam sc_tab_t SC_TAB = build_tab();

	function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
		if (v > 27'sd8388607) begin
			return 24'sd8388607;
		end else if (v < -27'sd8388608) begin
			return -24'sd8388608;
		end
		return v[23:0];
	endfunction

	function automatic logic signed [15:0] fld(input logic [47:0] r, input int k);
		return r[16*k +: 16];
	endfunction

	// exact round(prod / 255) for byte products
	function automatic logic [7:0] div255(input logic [15:0] prod);
		logic [16:0] t;
		logic [17:0] u;
		t = {1'b0, prod} + 17'd128;
		u = {1'b0, t} + {9'd0, t[16:8]};
		return u[15:8];
	endfunction

	// ---------------- config registers ----------------
	logic [47:0] camera_up_q, camera_right_q, facing_normal_q;
	logic [31:0] color_scale_q;
	logic rotation_enable_q;
	logic cfg_wr;
	pbqe_pkg::cfg_reg_t cfg_sel;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_sel = pbqe_pkg::cfg_reg_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			camera_up_q <= 48'd1073741824;
			camera_right_q <= 48'd16384;
			facing_normal_q <= 48'd211106232532992;
			color_scale_q <= 32'hFFFF_FFFF;
			rotation_enable_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_sel)
				pbqe_pkg::REG_CAMERA_UP: camera_up_q <= pwdata[47:0];
				pbqe_pkg::REG_CAMERA_RIGHT: camera_right_q <= pwdata[47:0];
				pbqe_pkg::REG_FACING_NORMAL: facing_normal_q <= pwdata[47:0];
				pbqe_pkg::REG_COLOR_SCALE: color_scale_q <= pwdata[31:0];
				pbqe_pkg::REG_ROTATION_ENABLE: rotation_enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			pbqe_pkg::REG_CAMERA_UP: prdata = {16'd0, camera_up_q};
			pbqe_pkg::REG_CAMERA_RIGHT: prdata = {16'd0, camera_right_q};
			pbqe_pkg::REG_FACING_NORMAL: prdata = {16'd0, facing_normal_q};
			pbqe_pkg::REG_COLOR_SCALE: prdata = {32'd0, color_scale_q};
			pbqe_pkg::REG_ROTATION_ENABLE: prdata = {63'd0, rotation_enable_q};
			default: prdata = '0;
		endcase
	end

	// doubled camera vectors and the normal
	logic signed [16:0] up2 [3];
	logic signed [16:0] rt2 [3];
	logic signed [15:0] nrm [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			up2[j] = {fld(camera_up_q, j), 1'b0};
			rt2[j] = {fld(camera_right_q, j), 1'b0};
			nrm[j] = fld(facing_normal_q, j);
		end
	end

	// ---------------- pipeline control ----------------
	logic s1_v, s2_v, s3_v, s4_v, s5_v, h_v, e1_v, e2_v;
	logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, h_free, e1_rdy, e2_rdy, issue;
	logic [1:0] cnt_q;

	assign e2_rdy = !e2_v || !vert_stall;
	assign e1_rdy = !e1_v || e2_rdy;
	assign issue = h_v && e1_rdy;
	assign h_free = !h_v || (issue && cnt_q == pbqe_pkg::CORNER_BL);
	assign s5_rdy = !s5_v || h_free;
	assign s4_rdy = !s4_v || s5_rdy;
	assign s3_rdy = !s3_v || s4_rdy;
	assign s2_rdy = !s2_v || s3_rdy;
	assign s1_rdy = !s1_v || s2_rdy;
	assign item_stall = !s1_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			s2_v <= 1'b0;
			s3_v <= 1'b0;
			s4_v <= 1'b0;
			s5_v <= 1'b0;
			h_v <= 1'b0;
			cnt_q <= '0;
			e1_v <= 1'b0;
			e2_v <= 1'b0;
		end else begin
			if (s1_rdy) s1_v <= item_valid;
			if (s2_rdy) s2_v <= s1_v;
			if (s3_rdy) s3_v <= s2_v;
			if (s4_rdy) s4_v <= s3_v;
			if (s5_rdy) s5_v <= s4_v;
			if (h_free) begin
				h_v <= s5_v;
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 2'd1;
			end
			if (e1_rdy) e1_v <= issue;
			if (e2_rdy) e2_v <= e1_v;
		end
	end

	// ---------------- stage 1: angle multiply, colour products ----------------
	logic signed [23:0] pos_s1 [3];
	logic [15:0] size_s1;
	logic signed [PW-1:0] p_s1;
	logic [15:0] cp_s1 [4];

	always_ff @(posedge clk) begin
		if (s1_rdy && item_valid) begin
			pos_s1[0] <= pos_x;
			pos_s1[1] <= pos_y;
			pos_s1[2] <= pos_z;
			size_s1 <= half_size;
			p_s1 <= PW'(spin_angle * KS);
			cp_s1[3] <= alpha_in * color_scale_q[31:24];
			cp_s1[2] <= red_in * color_scale_q[23:16];
			cp_s1[1] <= green_in * color_scale_q[15:8];
			cp_s1[0] <= blue_in * color_scale_q[7:0];
		end
	end

	// ---------------- stage 2: angle step with floor wrap, colour rounding ----------------
	logic signed [23:0] pos_s2 [3];
	logic [15:0] size_s2;
	logic [IW-1:0] idx_s2;
	logic [31:0] color_s2;
	logic signed [PW-1:0] p_rnd;
	logic signed [PW-1:0] n_full;
	logic signed [AW-1:0] n_a;

	always_comb begin
		p_rnd = p_s1 + (PW'(1) <<< 43);
		n_full = p_rnd >>> 44;
		n_a = n_full[AW-1:0];
		// step is within about 1.3 turns either way
		if (n_a < 0) n_a = n_a + STEPS_A;
		if (n_a < 0) n_a = n_a + STEPS_A;
		if (n_a >= STEPS_A) n_a = n_a - STEPS_A;
		if (n_a >= STEPS_A) n_a = n_a - STEPS_A;
	end

	always_ff @(posedge clk) begin
		if (s2_rdy && s1_v) begin
			pos_s2 <= pos_s1;
			size_s2 <= size_s1;
			idx_s2 <= n_a[IW-1:0];
			color_s2 <= {div255(cp_s1[3]), div255(cp_s1[2]),
				div255(cp_s1[1]), div255(cp_s1[0])};
		end
	end

	// ---------------- stage 3: cos/sin table ----------------
	logic signed [23:0] pos_s3 [3];
	logic [15:0] size_s3;
	logic [31:0] color_s3;
	logic signed [15:0] cos_s3, sin_s3;

	always_ff @(posedge clk) begin
		if (s3_rdy && s2_v) begin
			pos_s3 <= pos_s2;
			size_s3 <= size_s2;
			color_s3 <= color_s2;
			{cos_s3, sin_s3} <= SC_TAB[idx_s2];
		end
	end

	// ---------------- stage 4: rotate the up vector ----------------
	logic signed [23:0] pos_s4 [3];
	logic [15:0] size_s4;
	logic [31:0] color_s4;
	logic signed [BUW-1:0] bu_s4 [3];
	logic signed [33:0] rot_sum [3];
	logic signed [33:0] rot_rnd [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			rot_sum[j] = 34'(cos_s3 * up2[j]) + 34'(sin_s3 * rt2[j]);
			rot_rnd[j] = (rot_sum[j] + 34'sd8192) >>> 14;
		end
	end

	always_ff @(posedge clk) begin
		if (s4_rdy && s3_v) begin
			pos_s4 <= pos_s3;
			size_s4 <= size_s3;
			color_s4 <= color_s3;
			for (int j = 0; j < 3; j++) begin
				bu_s4[j] <= rot_rnd[j][BUW-1:0];
			end
		end
	end

	// ---------------- stage 5: right = up x normal, mode select ----------------
	logic signed [23:0] pos_s5 [3];
	logic [15:0] size_s5;
	logic [31:0] color_s5;
	logic signed [BUW-1:0] up_s5 [3];
	logic signed [RTW-1:0] rt_s5 [3];
	logic signed [35:0] crs [3];
	logic signed [35:0] crs_rnd [3];

	always_comb begin
		crs[0] = 36'(bu_s4[1] * nrm[2]) - 36'(bu_s4[2] * nrm[1]);
		crs[1] = 36'(bu_s4[2] * nrm[0]) - 36'(bu_s4[0] * nrm[2]);
		crs[2] = 36'(bu_s4[0] * nrm[1]) - 36'(bu_s4[1] * nrm[0]);
		for (int j = 0; j < 3; j++) begin
			crs_rnd[j] = (crs[j] + 36'sd8192) >>> 14;
		end
	end

	always_ff @(posedge clk) begin
		if (s5_rdy && s4_v) begin
			pos_s5 <= pos_s4;
			size_s5 <= size_s4;
			color_s5 <= color_s4;
			for (int j = 0; j < 3; j++) begin
				if (rotation_enable_q) begin
					up_s5[j] <= bu_s4[j];
					rt_s5[j] <= crs_rnd[j][RTW-1:0];
				end else begin
					up_s5[j] <= BUW'(up2[j]);
					rt_s5[j] <= RTW'(rt2[j]);
				end
			end
		end
	end

	// ---------------- hold register: one corner issued per cycle unless the vertex path stalls ----------------
	logic signed [23:0] pos_h [3];
	logic [15:0] size_h;
	logic [31:0] color_h;
	logic signed [BUW-1:0] up_h [3];
	logic signed [RTW-1:0] rt_h [3];

	always_ff @(posedge clk) begin
		if (h_free && s5_v) begin
			pos_h <= pos_s5;
			size_h <= size_s5;
			color_h <= color_s5;
			up_h <= up_s5;
			rt_h <= rt_s5;
		end
	end

	// corner offset: up sign + on the upper corners, right sign + on the right corners
	logic up_neg, rt_neg;
	logic signed [OFW-1:0] off [3];
	logic signed [MPW-1:0] mul [3];

	assign up_neg = (cnt_q == pbqe_pkg::CORNER_BR) || (cnt_q == pbqe_pkg::CORNER_BL);
	assign rt_neg = (cnt_q == pbqe_pkg::CORNER_UL) || (cnt_q == pbqe_pkg::CORNER_BL);

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			off[j] = (up_neg ? -OFW'(up_h[j]) : OFW'(up_h[j]))
				+ (rt_neg ? -OFW'(rt_h[j]) : OFW'(rt_h[j]));
			mul[j] = MPW'(off[j] * $signed({1'b0, size_h}));
		end
	end

	// ---------------- vertex stage 1: offset times size ----------------
	logic signed [MPW-1:0] mul_e1 [3];
	logic signed [23:0] pos_e1 [3];
	logic [31:0] color_e1;
	logic [1:0] corner_e1;

	always_ff @(posedge clk) begin
		if (e1_rdy && issue) begin
			mul_e1 <= mul;
			pos_e1 <= pos_h;
			color_e1 <= color_h;
			corner_e1 <= cnt_q;
		end
	end

	// ---------------- vertex stage 2: add, saturate, output register ----------------
	logic signed [MPW-1:0] mul_rnd [3];
	logic signed [26:0] vsum [3];
	logic signed [23:0] vert_e2 [3];
	logic [31:0] color_e2;
	logic [1:0] corner_e2;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mul_rnd[j] = (mul_e1[j] + MPW'(8192)) >>> 14;
			vsum[j] = 27'(pos_e1[j]) + mul_rnd[j][26:0];
		end
	end

	always_ff @(posedge clk) begin
		if (e2_rdy && e1_v) begin
			for (int j = 0; j < 3; j++) begin
				vert_e2[j] <= sat24(vsum[j]);
			end
			color_e2 <= color_e1;
			corner_e2 <= corner_e1;
		end
	end

	assign vert_valid = e2_v;
	assign vert_x = vert_e2[0];
	assign vert_y = vert_e2[1];
	assign vert_z = vert_e2[2];
	assign packed_color = color_e2;
	assign corner = corner_e2;
	assign last_corner = (corner_e2 == pbqe_pkg::CORNER_BL);

	// ---------------- assertions ----------------
	// corners of one particle leave in order
	a_corner_order: assert property (@(posedge clk) disable iff (!arst_n)
		(e2_v && !vert_stall && e1_v && corner_e2 != pbqe_pkg::CORNER_BL)
		|=> (corner_e2 == $past(corner_e2) + 2'd1))
		else $error("corner sequence broken");

	// a particle enters the hold register only at its first corner
	a_hold_load: assert property (@(posedge clk) disable iff (!arst_n)
		(h_free && s5_v) |=> (h_v && cnt_q == pbqe_pkg::CORNER_UL))
		else $error("hold register loaded mid-particle");

	// corner count only runs while a particle is held
	a_cnt_held: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != pbqe_pkg::CORNER_UL) |-> h_v)
		else $error("corner count without particle");

	// a stalled hold register keeps its corner
	a_cnt_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(h_v && !e1_rdy) |=> $stable(cnt_q))
		else $error("corner lost under stall");

endmodule

`default_nettype wire
